FILE: design/b64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg: shared types and constants of the base64 stream encoder
// Holds the command word passed from the front end to the emitter and the
// character mapping of the standard and url-safe alphabets.
// ----------------------------------------------------------------------------
package b64_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned SLOTS   = 4;
    localparam int unsigned SLOT_W  = 2;

    localparam logic [BYTE_W-1:0] CHAR_PAD     = 8'h3D; // '='
    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41; // 'A'
    localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61; // 'a'
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30; // '0'
    localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B; // '+'
    localparam logic [BYTE_W-1:0] CHAR_SLASH   = 8'h2F; // '/'
    localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D; // '-'
    localparam logic [BYTE_W-1:0] CHAR_UNDER   = 8'h5F; // '_'

    localparam logic [IDX_W-1:0] IDX_LOWER_BASE = 6'd26;
    localparam logic [IDX_W-1:0] IDX_DIGIT_BASE = 6'd52;
    localparam logic [IDX_W-1:0] IDX_PLUS       = 6'd62;
    localparam logic [IDX_W-1:0] IDX_SLASH      = 6'd63;

    // position of a byte inside its 3-byte group
    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2
    } b64_phase_t;

    // one byte worth of output characters
    typedef struct packed {
        logic [SLOTS-1:0][IDX_W-1:0] idx;      // 6-bit symbol per slot
        logic [SLOTS-1:0]            pad;      // slot emits '='
        logic [SLOT_W-1:0]           last_pos; // final slot in use
        logic                        fin;      // message ends here
    } b64_cmd_t;

    // map a 6-bit symbol to its ascii character
    function automatic logic [BYTE_W-1:0] b64_sym(input logic [IDX_W-1:0] idx,
                                                   input logic url);
        logic [BYTE_W-1:0] idx_ext;
        logic [BYTE_W-1:0] ch;
        idx_ext = {2'b00, idx};
        if (idx < IDX_LOWER_BASE)
            ch = CHAR_UPPER_A + idx_ext;
        else if (idx < IDX_DIGIT_BASE)
            ch = CHAR_LOWER_A + idx_ext - {2'b00, IDX_LOWER_BASE};
        else if (idx < IDX_PLUS)
            ch = CHAR_ZERO + idx_ext - {2'b00, IDX_DIGIT_BASE};
        else if (idx == IDX_PLUS)
            ch = url ? CHAR_MINUS : CHAR_PLUS;
        else
            ch = url ? CHAR_UNDER : CHAR_SLASH;
        return ch;
    endfunction

endpackage

FILE: design/b64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_front: byte intake and group tracking
// Accepts raw bytes, tracks the group phase and leftover bits, and turns
// each byte into a command listing the characters it produces.
// ----------------------------------------------------------------------------
module b64_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [b64_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                        s_tlast,
    input  logic                        q_full,
    output logic                        q_push,
    output b64_pkg::b64_cmd_t           q_cmd
);

    b64_pkg::b64_phase_t phase_reg, phase_next;
    logic [3:0]          carry_reg, carry_next;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // next group state
    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        unique case (phase_reg)
            b64_pkg::PHASE_1:
            begin
                if (s_tlast)
                begin
                    phase_next = b64_pkg::PHASE_0;
                    carry_next = '0;
                end
                else
                begin
                    phase_next = b64_pkg::PHASE_2;
                    carry_next = s_tdata[3:0];
                end
            end
            b64_pkg::PHASE_2:
            begin
                phase_next = b64_pkg::PHASE_0;
                carry_next = '0;
            end
            default:
            begin
                if (s_tlast)
                begin
                    phase_next = b64_pkg::PHASE_0;
                    carry_next = '0;
                end
                else
                begin
                    phase_next = b64_pkg::PHASE_1;
                    carry_next = {2'b00, s_tdata[1:0]};
                end
            end
        endcase
    end

    // command for the characters of this byte
    always_comb
    begin
        q_cmd     = '0;
        q_cmd.fin = s_tlast;
        unique case (phase_reg)
            b64_pkg::PHASE_1:
            begin
                q_cmd.idx[0] = {carry_reg[1:0], s_tdata[7:4]};
                if (s_tlast)
                begin
                    q_cmd.idx[1]   = {s_tdata[3:0], 2'b00};
                    q_cmd.pad[2]   = 1'b1;
                    q_cmd.last_pos = 2'd2;
                end
                else
                begin
                    q_cmd.last_pos = 2'd0;
                end
            end
            b64_pkg::PHASE_2:
            begin
                q_cmd.idx[0]   = {carry_reg, s_tdata[7:6]};
                q_cmd.idx[1]   = s_tdata[5:0];
                q_cmd.last_pos = 2'd1;
            end
            default:
            begin
                q_cmd.idx[0] = s_tdata[7:2];
                if (s_tlast)
                begin
                    q_cmd.idx[1]   = {s_tdata[1:0], 4'b0000};
                    q_cmd.pad[2]   = 1'b1;
                    q_cmd.pad[3]   = 1'b1;
                    q_cmd.last_pos = 2'd3;
                end
                else
                begin
                    q_cmd.last_pos = 2'd0;
                end
            end
        endcase
    end

    // group state advances on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64_pkg::PHASE_0;
            carry_reg <= '0;
        end
        else if (q_push)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    // leftover bits stay within the width the phase allows
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == b64_pkg::PHASE_1) |-> (carry_reg[3:2] == 2'b00))
        else $error("carry holds more than two bits in phase one");

    // a final byte always closes the group
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && s_tlast) |=> (phase_reg == b64_pkg::PHASE_0) && (carry_reg == '0))
        else $error("group state not cleared after final byte");

endmodule

FILE: design/b64_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_queue: command queue between intake and emitter
// Small register fifo so the intake and the emitter stall independently.
// ----------------------------------------------------------------------------
module b64_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64_pkg::b64_cmd_t  push_cmd,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output b64_pkg::b64_cmd_t  head_cmd
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    b64_pkg::b64_cmd_t  slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    // pointer and fill count updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    // no write into a full queue, no read from an empty one
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && !not_empty))
        else $error("queue overflow or underflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

FILE: design/b64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_back: character emitter
// Walks the slots of each command, one character per cycle unless m_tready
// stalls; maps symbols through the selected alphabet into an output register.
// ----------------------------------------------------------------------------
module b64_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        url_safe,
    input  logic                        q_valid,
    input  b64_pkg::b64_cmd_t           q_cmd,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [b64_pkg::BYTE_W-1:0]  m_tdata,
    output logic                        m_tlast
);

    b64_pkg::b64_cmd_t                cur_reg, cur_next;
    logic                             cur_valid_reg, cur_valid_next;
    logic [b64_pkg::SLOT_W-1:0]       pos_reg, pos_next;
    logic                             out_valid_reg, out_valid_next;
    logic [b64_pkg::BYTE_W-1:0]       out_char_reg, out_char_next;
    logic                             out_last_reg, out_last_next;

    logic advance;
    logic at_end;
    logic load;

    // output register frees up when empty or being taken
    assign advance = cur_valid_reg && (!out_valid_reg || m_tready);
    assign at_end  = (pos_reg == cur_reg.last_pos);
    assign load    = !cur_valid_reg || (advance && at_end);
    assign q_pop   = load && q_valid;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // slot walk and command reload
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        if (load)
        begin
            cur_next       = q_cmd;
            cur_valid_next = q_valid;
            pos_next       = '0;
        end
        else if (advance)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // character for the current slot
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_char_next  = cur_reg.pad[pos_reg] ? b64_pkg::CHAR_PAD
                           : b64_pkg::b64_sym(cur_reg.idx[pos_reg], url_safe);
            out_last_next  = at_end && cur_reg.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // slot position never runs past the command
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (pos_reg <= cur_reg.last_pos))
        else $error("slot position beyond last slot");

    // a last character always comes from a final command's last slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !(at_end && cur_reg.fin)) |=> !out_last_reg)
        else $error("last mark on an inner character");

endmodule

FILE: design/base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder: streaming base64 encoder
// Raw bytes in, base64 characters out, with padding on the final byte.
//
//  channel   dir  tdata          tuser/tlast      notes
//  s_*       in   [7:0] byte     tlast = final    one byte per transaction
//  m_*       out  [7:0] ascii    tlast = last     one character per transaction
//  cfg_*     in   cfg_wdata[0]   -                url-safe alphabet select
//
// Each byte yields 1 to 4 characters; the emitter sends one character per
// cycle while m_tready accepts them. Intake takes a byte per cycle while the
// command queue has room. Reset clears the group state, queue and output
// register; the alphabet select resets to standard. Output stalls back up
// through the queue into s_tready.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic                url_safe_reg;
    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_valid;
    b64_pkg::b64_cmd_t   push_cmd;
    b64_pkg::b64_cmd_t   head_cmd;

    // alphabet select register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            url_safe_reg <= 1'b0;
        else if (cfg_we)
            url_safe_reg <= cfg_wdata;
    end

    b64_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    b64_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .url_safe (url_safe_reg),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
